### hdl/ecer_pkg.sv
// ----------------------------------------------------------------------------
// ecer_pkg
// Shared types, codes and helpers of the encoder count extender readout.
// ----------------------------------------------------------------------------
package ecer_pkg;

  // widest encoder address (up to eight encoders)
  localparam int ENC_ADDR_W = 3;
  localparam int MAX_WORDS  = 4;

  // operation field codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_HEADER = 1'b1;

  // register indexes on the config port
  localparam logic [1:0] REG_COMMAND_MASK   = 2'd0;
  localparam logic [1:0] REG_READ_CODE      = 2'd1;
  localparam logic [1:0] REG_CLEAR_CODE     = 2'd2;
  localparam logic [1:0] REG_SELECTOR_SHIFT = 2'd3;

  typedef struct packed {
    logic [7:0] command_mask;
    logic [7:0] read_code;
    logic [7:0] clear_code;
    logic [2:0] selector_shift;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIFF,
    ST_ACC,
    ST_SCAN
  } state_t;

  typedef enum logic [1:0] {
    DP_NONE,
    DP_DIFF,
    DP_ACC,
    DP_MARK
  } dp_op_t;

  typedef struct packed {
    dp_op_t                  op;
    logic [ENC_ADDR_W-1:0]   addr;
  } dp_ctrl_t;

  function automatic logic [31:0] swap_bytes(input logic [31:0] v);
    swap_bytes = {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

### hdl/ecer_if.sv
// ----------------------------------------------------------------------------
// ecer_if
// Request channels of the encoder count extender: input items and results.
// ----------------------------------------------------------------------------
interface ecer_item_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [1:0]  encoder_index;
  logic [15:0] raw_count;
  logic [7:0]  header;

  modport source (output valid, operation, encoder_index, raw_count, header,
                  input ready);
  modport sink   (input valid, operation, encoder_index, raw_count, header,
                  output ready);
endinterface

interface ecer_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  encoder_index_res;
  logic [31:0] position_word;
  logic        last;

  modport source (output valid, encoder_index_res, position_word, last,
                  input ready);
  modport sink   (input valid, encoder_index_res, position_word, last,
                  output ready);
endinterface

### hdl/ecer_cfg.sv
// ----------------------------------------------------------------------------
// ecer_cfg
// APB-style register bank: command mask, read/clear codes, selector shift.
// ----------------------------------------------------------------------------
module ecer_cfg
  import ecer_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  cfg_t       regs;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign cfg     = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.command_mask   <= 8'h0F;
      regs.read_code      <= 8'h01;
      regs.clear_code     <= 8'h02;
      regs.selector_shift <= 3'd4;
    end else if (wr_en) begin
      case (reg_idx)
        REG_COMMAND_MASK:   regs.command_mask   <= pwdata[7:0];
        REG_READ_CODE:      regs.read_code      <= pwdata[7:0];
        REG_CLEAR_CODE:     regs.clear_code     <= pwdata[7:0];
        REG_SELECTOR_SHIFT: regs.selector_shift <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_COMMAND_MASK:   prdata = {24'd0, regs.command_mask};
      REG_READ_CODE:      prdata = {24'd0, regs.read_code};
      REG_CLEAR_CODE:     prdata = {24'd0, regs.clear_code};
      REG_SELECTOR_SHIFT: prdata = {29'd0, regs.selector_shift};
      default:            prdata = 32'd0;
    endcase
  end

endmodule

### hdl/ecer_dp.sv
// ----------------------------------------------------------------------------
// ecer_dp
// Position, previous-count and clear-pending storage around one shared
// 32-bit adder (count difference first, then accumulate).
// ----------------------------------------------------------------------------
module ecer_dp
  import ecer_pkg::*;
#(
  parameter int ENC_COUNT = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  dp_ctrl_t    ctrl,
  input  logic [15:0] raw,
  output logic [31:0] pos_rd
);

  localparam int IDX_W = (ENC_COUNT > 1) ? $clog2(ENC_COUNT) : 1;

  logic [31:0] positions       [ENC_COUNT];
  logic [15:0] previous_counts [ENC_COUNT];
  logic [ENC_COUNT-1:0] clear_pending;

  logic [IDX_W-1:0] addr;
  logic [15:0]      diff;
  logic [31:0]      add_a;
  logic [31:0]      add_b;
  logic             add_cin;
  logic [31:0]      sum;

  assign addr   = IDX_W'(ctrl.addr);
  assign pos_rd = positions[addr];

  // shared adder: raw - prev on DP_DIFF, position + sext(diff) on DP_ACC
  always_comb begin
    case (ctrl.op)
      DP_DIFF: begin
        add_a   = {16'd0, raw};
        add_b   = {16'd0, ~previous_counts[addr]};
        add_cin = 1'b1;
      end
      DP_ACC: begin
        add_a   = positions[addr];
        add_b   = {{16{diff[15]}}, diff};
        add_cin = 1'b0;
      end
      default: begin
        add_a   = 32'd0;
        add_b   = 32'd0;
        add_cin = 1'b0;
      end
    endcase
    sum = add_a + add_b + {31'd0, add_cin};
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == DP_DIFF) begin
      diff <= sum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ENC_COUNT; k++) begin
        positions[k]       <= 32'd0;
        previous_counts[k] <= 16'd0;
      end
      clear_pending <= '0;
    end else begin
      case (ctrl.op)
        DP_ACC: begin
          positions[addr]       <= clear_pending[addr] ? 32'd0 : sum;
          previous_counts[addr] <= raw;
          clear_pending[addr]   <= 1'b0;
        end
        DP_MARK: clear_pending[addr] <= 1'b1;
        default: ;
      endcase
    end
  end

endmodule

### hdl/ecer_seq.sv
// ----------------------------------------------------------------------------
// ecer_seq
// Sequencer: latches and decodes one request, drives the datapath steps and
// scans one encoder per cycle unless stalled: reads load the result register.
// ----------------------------------------------------------------------------
module ecer_seq
  import ecer_pkg::*;
#(
  parameter int ENC_COUNT = 4
) (
  input  logic          clk,
  input  logic          rst,
  ecer_item_if.sink     item,
  ecer_result_if.source result,
  input  cfg_t          cfg,
  input  logic [31:0]   pos_rd,
  output dp_ctrl_t      ctrl,
  output logic [15:0]   raw
);

  localparam int CW = $clog2(ENC_COUNT + 1);
  localparam logic [7:0] ENC_MASK = 8'((1 << ENC_COUNT) - 1);

  state_t state, state_next;

  logic        op_q;
  logic [1:0]  idx_q;
  logic [15:0] raw_q;
  logic [7:0]  header_q;
  logic [CW-1:0] i_q;
  logic [1:0]  n_q;
  logic        scan_rd_q;

  logic        out_valid;
  logic [1:0]  out_idx;
  logic [31:0] out_word;
  logic        out_last;

  logic [7:0] code;
  logic [7:0] sel;
  logic [7:0] above;
  logic       idx_ok;
  logic       read_hit;
  logic       clear_hit;
  logic       scan_end;
  logic       cur_bit;
  logic       more_above;
  logic       last_word;
  logic       out_free;
  logic       load_out;

  assign raw = raw_q;

  assign code      = header_q & cfg.command_mask;
  assign sel       = header_q >> cfg.selector_shift;
  assign idx_ok    = {2'b00, idx_q} < 4'(ENC_COUNT);
  assign read_hit  = (code == cfg.read_code);
  assign clear_hit = !read_hit && (code == cfg.clear_code);
  assign scan_end  = (i_q == CW'(ENC_COUNT));
  assign cur_bit   = sel[3'(i_q)];

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      above[j] = (j > int'(i_q));
    end
  end

  assign more_above = |(sel & ENC_MASK & above);
  assign last_word  = (n_q == 2'(MAX_WORDS - 1)) || !more_above;
  assign out_free   = !out_valid || result.ready;

  // outputs
  always_comb begin
    item.ready = (state == ST_IDLE);
    load_out   = 1'b0;
    ctrl.op    = DP_NONE;
    ctrl.addr  = ENC_ADDR_W'(idx_q);
    case (state)
      ST_DIFF: ctrl.op = DP_DIFF;
      ST_ACC:  ctrl.op = DP_ACC;
      ST_SCAN: begin
        ctrl.addr = ENC_ADDR_W'(i_q);
        if (!scan_end && cur_bit) begin
          if (scan_rd_q) begin
            load_out = out_free;
          end else begin
            ctrl.op = DP_MARK;
          end
        end
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (item.valid) state_next = ST_DECODE;
      ST_DECODE: begin
        if (op_q == OP_SAMPLE) begin
          state_next = idx_ok ? ST_DIFF : ST_IDLE;
        end else begin
          state_next = (read_hit || clear_hit) ? ST_SCAN : ST_IDLE;
        end
      end
      ST_DIFF: state_next = ST_ACC;
      ST_ACC:  state_next = ST_IDLE;
      ST_SCAN: begin
        if (scan_end) begin
          state_next = ST_IDLE;
        end else if (cur_bit) begin
          if (!scan_rd_q) begin
            state_next = ST_IDLE;
          end else if (load_out && last_word) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      op_q     <= item.operation;
      idx_q    <= item.encoder_index;
      raw_q    <= item.raw_count;
      header_q <= item.header;
    end
    if (state == ST_DECODE) begin
      i_q       <= '0;
      n_q       <= 2'd0;
      scan_rd_q <= read_hit;
    end else if (state == ST_SCAN && !scan_end && (!cur_bit || load_out)) begin
      i_q <= i_q + CW'(1);
      if (load_out) begin
        n_q <= n_q + 2'd1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_idx  <= 2'(i_q);
      out_word <= swap_bytes(pos_rd);
      out_last <= last_word;
    end
  end

  assign result.valid             = out_valid;
  assign result.encoder_index_res = out_idx;
  assign result.position_word     = out_word;
  assign result.last              = out_last;

  a_acc_after_diff: assert property (@(posedge clk) disable iff (rst)
    state == ST_ACC |-> $past(state) == ST_DIFF)
    else $error("accumulate step without difference step");

  a_mark_only_clear: assert property (@(posedge clk) disable iff (rst)
    ctrl.op == DP_MARK |-> state == ST_SCAN && !scan_rd_q)
    else $error("clear mark outside a clear scan");

  a_load_only_read: assert property (@(posedge clk) disable iff (rst)
    load_out |-> state == ST_SCAN && scan_rd_q)
    else $error("result loaded outside a read scan");

  a_scan_continues: assert property (@(posedge clk) disable iff (rst)
    load_out && !last_word |=> state == ST_SCAN)
    else $error("read scan ended before its last word");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result.ready |-> !load_out)
    else $error("pending result overwritten");

endmodule

### hdl/encoder_count_extender_readout.sv
// ----------------------------------------------------------------------------
// encoder_count_extender_readout
// Extends 16-bit encoder counts to 32-bit positions and reads them out on
// command headers, with one shared adder under a small sequencer.
// ----------------------------------------------------------------------------
// Sample request: decode, diff, accumulate, then back to idle for the next item.
// Header request: decode, then back to idle for an unknown code, else a scan that
//   ends on the last read word, the first marked encoder or an empty selection.
// Result words go out through the result register; result stalls hold the scan.
// Synchronous reset clears positions, previous counts, clear flags and result valid.
// ----------------------------------------------------------------------------
module encoder_count_extender_readout
  import ecer_pkg::*;
#(
  parameter int ENC_COUNT = 4
) (
  input  logic          clk,
  input  logic          rst,
  ecer_item_if.sink     item,
  ecer_result_if.source result,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  cfg_t        cfg;
  dp_ctrl_t    ctrl;
  logic [15:0] raw;
  logic [31:0] pos_rd;

  ecer_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ecer_dp #(
    .ENC_COUNT (ENC_COUNT)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .raw    (raw),
    .pos_rd (pos_rd)
  );

  ecer_seq #(
    .ENC_COUNT (ENC_COUNT)
  ) u_seq (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result),
    .cfg    (cfg),
    .pos_rd (pos_rd),
    .ctrl   (ctrl),
    .raw    (raw)
  );

endmodule

### tb/tb_encoder_count_extender_readout.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_encoder_count_extender_readout
// Drives encoder samples and command headers into the count extender, keeps
// its own copy of the positions, previous counts and pending clears, and checks
// every readout word in order. A short directed table comes first, then random
// items per register setting, with random stalls on both channels, but the last.
// ----------------------------------------------------------------------------
module tb_encoder_count_extender_readout
  import ecer_pkg::*;
();

  localparam int N_ENC = 4;
  localparam int N_DIR = 23;
  localparam int N_PHASE = 6;
  localparam int ITEMS_PER_PHASE = 68;
  localparam int SETTLE = 12;

  typedef struct packed {
    logic [1:0]  idx;
    logic [31:0] word;
    logic        last;
  } word_t;

  // directed row: when typed is set, the single readout word is written in
  typedef struct packed {
    logic        op;
    logic [1:0]  idx;
    logic [15:0] raw;
    logic [7:0]  hdr;
    logic        typed;
    logic [1:0]  t_idx;
    logic [31:0] t_word;
  } row_t;

  localparam row_t DIR_ROWS [N_DIR] = '{
    '{OP_HEADER, 2'd0, 16'h0000, 8'h11, 1'b1, 2'd0, 32'h0000_0000},
    '{OP_HEADER, 2'd3, 16'hFFFF, 8'hF1, 1'b0, 2'd0, 32'h0},
    '{OP_SAMPLE, 2'd0, 16'hFFFF, 8'h00, 1'b0, 2'd0, 32'h0},
    '{OP_HEADER, 2'd0, 16'h0000, 8'h11, 1'b1, 2'd0, 32'hFFFF_FFFF},
    '{OP_SAMPLE, 2'd1, 16'h7FFF, 8'hFF, 1'b0, 2'd0, 32'h0},
    '{OP_SAMPLE, 2'd1, 16'hFFFF, 8'h00, 1'b0, 2'd0, 32'h0},
    '{OP_SAMPLE, 2'd2, 16'h8000, 8'h00, 1'b0, 2'd0, 32'h0},
    '{OP_HEADER, 2'd0, 16'h0000, 8'h21, 1'b1, 2'd1, 32'hFFFF_FFFF},
    '{OP_HEADER, 2'd0, 16'h0000, 8'h41, 1'b1, 2'd2, 32'h0080_FFFF},
    '{OP_HEADER, 2'd0, 16'h0000, 8'h01, 1'b0, 2'd0, 32'h0},
    '{OP_HEADER, 2'd0, 16'h0000, 8'hF3, 1'b0, 2'd0, 32'h0},
    '{OP_HEADER, 2'd0, 16'h0000, 8'hF0, 1'b0, 2'd0, 32'h0},
    '{OP_HEADER, 2'd0, 16'h0000, 8'h62, 1'b0, 2'd0, 32'h0},
    '{OP_SAMPLE, 2'd1, 16'h0005, 8'h00, 1'b0, 2'd0, 32'h0},
    '{OP_SAMPLE, 2'd2, 16'h8001, 8'h00, 1'b0, 2'd0, 32'h0},
    '{OP_HEADER, 2'd3, 16'hABCD, 8'h61, 1'b0, 2'd0, 32'h0},
    '{OP_SAMPLE, 2'd3, 16'h1234, 8'hFF, 1'b0, 2'd0, 32'h0},
    '{OP_HEADER, 2'd0, 16'h0000, 8'h02, 1'b0, 2'd0, 32'h0},
    '{OP_SAMPLE, 2'd0, 16'h0000, 8'h00, 1'b0, 2'd0, 32'h0},
    '{OP_HEADER, 2'd2, 16'h5555, 8'hF1, 1'b0, 2'd0, 32'h0},
    '{OP_HEADER, 2'd0, 16'h0000, 8'h82, 1'b0, 2'd0, 32'h0},
    '{OP_SAMPLE, 2'd3, 16'h1000, 8'h00, 1'b0, 2'd0, 32'h0},
    '{OP_HEADER, 2'd0, 16'h0000, 8'h81, 1'b1, 2'd3, 32'h0000_0000}
  };

  // mask, read code, clear code, selector shift
  localparam cfg_t PHASES [N_PHASE] = '{
    '{8'h0F, 8'h01, 8'h02, 3'd4},
    '{8'h00, 8'h00, 8'h00, 3'd0},
    '{8'hFF, 8'hFF, 8'h80, 3'd7},
    '{8'hF0, 8'h30, 8'h50, 3'd0},
    '{8'h03, 8'h03, 8'h01, 3'd2},
    '{8'h0F, 8'h05, 8'h05, 3'd4}
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ecer_item_if   item_ch ();
  ecer_result_if result_ch ();

  encoder_count_extender_readout #(.ENC_COUNT(N_ENC)) u_dut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // shadow of the block
  cfg_t        cfg;
  logic [31:0] position [N_ENC];
  logic [15:0] prev_count [N_ENC];
  logic        clear_mark [N_ENC];

  word_t words_due [$];
  int    mismatches = 0;
  bit    idling = 1'b1;

  task automatic note_mismatch(input string what, input word_t exp_w, input word_t act_w);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: expected idx %0d word %h last %b, got idx %0d word %h last %b",
               $realtime, what, exp_w.idx, exp_w.word, exp_w.last,
               act_w.idx, act_w.word, act_w.last);
  endtask

  task automatic apply_item(input logic op, input logic [1:0] idx, input logic [15:0] raw,
                            input logic [7:0] hdr, input bit keep);
    logic [15:0] delta;
    logic [7:0]  code;
    logic [7:0]  sel;
    word_t       w;
    int          n;
    if (op == OP_SAMPLE) begin
      delta = raw - prev_count[idx];
      position[idx] = position[idx] + {{16{delta[15]}}, delta};
      prev_count[idx] = raw;
      if (clear_mark[idx]) begin
        clear_mark[idx] = 1'b0;
        position[idx] = '0;
      end
    end else begin
      code = hdr & cfg.command_mask;
      sel = hdr >> cfg.selector_shift;
      if (code == cfg.read_code) begin
        n = 0;
        for (int i = 0; i < N_ENC && n < MAX_WORDS; i++) begin
          if (sel[i]) begin
            w.idx = 2'(i);
            for (int b = 0; b < 4; b++)
              w.word[8*b +: 8] = position[i][8*(3-b) +: 8];
            // last mark goes on the final word of the run
            w.last = 1'b1;
            for (int j = i + 1; j < N_ENC && n + 1 < MAX_WORDS; j++)
              if (sel[j]) w.last = 1'b0;
            if (keep) words_due.push_back(w);
            n++;
          end
        end
      end else if (code == cfg.clear_code) begin
        for (int i = 0; i < N_ENC; i++) begin
          if (sel[i]) begin
            clear_mark[i] = 1'b1;
            break;
          end
        end
      end
    end
  endtask

  // returns at the edge where the request is taken
  task automatic send_item(input logic op, input logic [1:0] idx, input logic [15:0] raw,
                           input logic [7:0] hdr);
    if (idling && $urandom_range(0, 4) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    item_ch.valid         <= 1'b1;
    item_ch.operation     <= op;
    item_ch.encoder_index <= idx;
    item_ch.raw_count     <= raw;
    item_ch.header        <= hdr;
    do @(posedge clk); while (!item_ch.ready);
  endtask

  task automatic random_item();
    logic        op;
    logic [1:0]  idx;
    logic [15:0] raw;
    logic [7:0]  hdr;
    logic [7:0]  goal;
    int          pick;
    op   = ($urandom_range(0, 1) == 1) ? OP_HEADER : OP_SAMPLE;
    idx  = 2'($urandom);
    raw  = 16'($urandom);
    hdr  = 8'($urandom);
    pick = $urandom_range(0, 9);
    if (op == OP_SAMPLE) begin
      if (pick < 5)
        raw = prev_count[idx] + 16'($urandom_range(0, 600)) - 16'd300;
      else if (pick == 5)
        raw = prev_count[idx] + 16'h7FFF;
      else if (pick == 6)
        raw = prev_count[idx] + 16'h8001;
    end else begin
      if (pick < 6) goal = cfg.read_code;
      else if (pick < 8) goal = cfg.clear_code;
      else goal = hdr;
      hdr = (hdr & ~cfg.command_mask) | (goal & cfg.command_mask);
    end
    send_item(op, idx, raw, hdr);
    apply_item(op, idx, raw, hdr, 1'b1);
  endtask

  // wait for the block to go quiet before touching registers or ending
  task automatic drain();
    item_ch.valid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] r, input logic [7:0] value);
    logic [31:0] back;
    logic [31:0] want;
    word_t       exp_w;
    word_t       act_w;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= {24'b0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (r)
      REG_COMMAND_MASK:   cfg.command_mask = value;
      REG_READ_CODE:      cfg.read_code = value;
      REG_CLEAR_CODE:     cfg.clear_code = value;
      REG_SELECTOR_SHIFT: cfg.selector_shift = value[2:0];
      default: ;
    endcase
    want = (r == REG_SELECTOR_SHIFT) ? {29'b0, value[2:0]} : {24'b0, value};
    // read it back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    back = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (back !== want) begin
      exp_w = '{idx: r, word: want, last: 1'b0};
      act_w = '{idx: r, word: back, last: 1'b0};
      note_mismatch("register readback", exp_w, act_w);
    end
  endtask

  // result side: random stall bursts, compare against the oldest expectation
  int    hold_left = 0;
  word_t got_w;
  word_t want_w;

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (idling && $urandom_range(0, 3) == 0) begin
      result_ch.ready <= 1'b0;
      hold_left <= $urandom_range(1, 11) - 1;
    end else begin
      result_ch.ready <= 1'b1;
      hold_left <= $urandom_range(0, 19);
    end
    if (!rst && result_ch.valid && result_ch.ready) begin
      got_w = '{idx: result_ch.encoder_index_res, word: result_ch.position_word,
                last: result_ch.last};
      if (words_due.size() == 0) begin
        note_mismatch("unexpected word", '0, got_w);
      end else begin
        want_w = words_due.pop_front();
        if (got_w !== want_w) note_mismatch("readout word", want_w, got_w);
      end
    end
  end

  initial begin
    rst                   = 1'b1;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    item_ch.valid         = 1'b0;
    item_ch.operation     = OP_SAMPLE;
    item_ch.encoder_index = '0;
    item_ch.raw_count     = '0;
    item_ch.header        = '0;
    result_ch.ready       = 1'b0;
    cfg = '{command_mask: 8'h0F, read_code: 8'h01, clear_code: 8'h02, selector_shift: 3'd4};
    for (int i = 0; i < N_ENC; i++) begin
      position[i]   = '0;
      prev_count[i] = '0;
      clear_mark[i] = 1'b0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (DIR_ROWS[r]) begin
      send_item(DIR_ROWS[r].op, DIR_ROWS[r].idx, DIR_ROWS[r].raw, DIR_ROWS[r].hdr);
      apply_item(DIR_ROWS[r].op, DIR_ROWS[r].idx, DIR_ROWS[r].raw, DIR_ROWS[r].hdr,
                 !DIR_ROWS[r].typed);
      if (DIR_ROWS[r].typed)
        words_due.push_back('{idx: DIR_ROWS[r].t_idx, word: DIR_ROWS[r].t_word, last: 1'b1});
    end
    drain();

    for (int p = 0; p < N_PHASE; p++) begin
      idling = (p != N_PHASE - 1);
      write_reg(REG_COMMAND_MASK, PHASES[p].command_mask);
      write_reg(REG_READ_CODE, PHASES[p].read_code);
      write_reg(REG_CLEAR_CODE, PHASES[p].clear_code);
      write_reg(REG_SELECTOR_SHIFT, {5'b0, PHASES[p].selector_shift});
      for (int k = 0; k < ITEMS_PER_PHASE; k++) random_item();
      drain();
    end

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
